FILE: src/lpbrf_pkg.sv
// Package with the field widths, function codes and status codes of the message ring FIFO.
package lpbrf_pkg;

    localparam int DATA_W   = 8;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 3;

    // The store must hold more than this many used bytes before a pop is served.
    localparam int FREE_MIN = 2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_PUSH_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_POP_BYTE  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BUSY      = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_LEN  = 3'd5;

endpackage

FILE: src/lpbrf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lpbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/length_prefixed_byte_ring_fifo_unit.sv
// Top level of the ring FIFO that stores whole length-prefixed messages.
//
// A push transfer returns one status result. A pop that is served first reads
// the length byte at the head, then returns its message bytes at one per cycle
// while result_stall is low; a pop that is refused (busy, empty or zero length)
// returns one result. The rate is set by the single read port and single write
// port of the byte store, which a pop uses once per byte. After reset the block
// writes zero to every store entry, and holds item_stall high during that pass.
// A finished result waits in the output register, and the next item is taken in
// the cycle that register is drained.
module length_prefixed_byte_ring_fifo_unit #(
    parameter int DEPTH   = 256,
    parameter int MAX_MSG = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                func,
    input  logic [lpbrf_pkg::DATA_W-1:0]        data,
    input  logic                                first,
    input  logic [lpbrf_pkg::LEN_W-1:0]         msg_len,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [lpbrf_pkg::STATUS_W-1:0]      status,
    output logic [lpbrf_pkg::DATA_W-1:0]        out_byte,
    output logic [lpbrf_pkg::LEN_W-1:0]         length,
    output logic                                last
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int XW = FW + 8;

    localparam logic [1:0] ST_CLEAR    = 2'd0;
    localparam logic [1:0] ST_IDLE     = 2'd1;
    localparam logic [1:0] ST_POP_LEN  = 2'd2;
    localparam logic [1:0] ST_POP_BYTE = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [AW-1:0]                   head_reg, head_next;
    logic [AW-1:0]                   tail_reg, tail_next;
    logic [AW-1:0]                   clr_reg, clr_next;
    logic [FW-1:0]                   free_reg, free_next;
    logic                            push_open_reg, push_open_next;
    logic                            push_drop_reg, push_drop_next;
    logic [lpbrf_pkg::LEN_W-1:0]     push_left_reg, push_left_next;
    logic [lpbrf_pkg::LEN_W-1:0]     n_reg, n_next;
    logic [lpbrf_pkg::LEN_W-1:0]     cnt_reg, cnt_next;

    logic                            out_valid_reg, out_valid_next;
    logic [lpbrf_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [lpbrf_pkg::DATA_W-1:0]    out_byte_reg, out_byte_next;
    logic [lpbrf_pkg::LEN_W-1:0]     out_len_reg, out_len_next;
    logic                            out_last_reg, out_last_next;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [lpbrf_pkg::DATA_W-1:0]    ram_wdata;
    logic                            ram_re;
    logic [AW-1:0]                   ram_raddr;
    logic [lpbrf_pkg::DATA_W-1:0]    ram_rdata;

    logic                            slot_free;
    logic                            item_take;
    logic [AW-1:0]                   head_inc;
    logic [AW-1:0]                   tail_inc;
    logic [XW-1:0]                   free_x;
    logic [XW-1:0]                   len_x;
    logic [XW-1:0]                   reclaim_sum;
    logic [FW-1:0]                   free_reclaimed;
    logic [XW-1:0]                   free_rec_x;
    logic                            refuse;
    logic                            empty;
    logic [XW-1:0]                   return_sum;
    logic [lpbrf_pkg::LEN_W-1:0]     head_len;
    logic [lpbrf_pkg::LEN_W-1:0]     left_dec;

    lpbrf_ram #(
        .WIDTH (lpbrf_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_free  = !out_valid_reg || !result_stall;
    assign item_stall = !((state_reg == ST_IDLE) && slot_free);
    assign item_take  = item_valid && !item_stall;

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign out_byte     = out_byte_reg;
    assign length       = out_len_reg;
    assign last         = out_last_reg;

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);

    // A new first byte hands the unwritten part of an open admitted message back.
    assign free_x      = XW'(free_reg);
    assign len_x       = XW'(msg_len);
    assign reclaim_sum = free_x + XW'(push_left_reg);
    always_comb
    begin
        if (push_open_reg && !push_drop_reg)
        begin
            free_reclaimed = (reclaim_sum > XW'(DEPTH)) ? FW'(DEPTH) : reclaim_sum[FW-1:0];
        end
        else
        begin
            free_reclaimed = free_reg;
        end
    end
    assign free_rec_x = XW'(free_reclaimed);
    assign refuse     = (len_x > XW'(MAX_MSG)) || (free_rec_x < len_x)
                        || (free_rec_x <= XW'(lpbrf_pkg::FREE_MIN));
    assign empty      = (free_x + XW'(lpbrf_pkg::FREE_MIN)) >= XW'(DEPTH);
    assign return_sum = free_x + XW'(n_reg);
    assign head_len   = (ram_rdata > lpbrf_pkg::DATA_W'(MAX_MSG))
                        ? lpbrf_pkg::LEN_W'(MAX_MSG) : ram_rdata[lpbrf_pkg::LEN_W-1:0];
    assign left_dec   = push_left_reg - lpbrf_pkg::LEN_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        clr_next        = clr_reg;
        free_next       = free_reg;
        push_open_next  = push_open_reg;
        push_drop_next  = push_drop_reg;
        push_left_next  = push_left_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_reg;
        ram_wdata       = data;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (item_take)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = '0;
                    out_len_next    = '0;
                    out_last_next   = 1'b1;
                    if (func == lpbrf_pkg::FUNC_PUSH)
                    begin
                        if (first)
                        begin
                            free_next      = free_reclaimed;
                            push_open_next = 1'b0;
                            push_drop_next = 1'b0;
                            push_left_next = '0;
                            if (msg_len == '0)
                            begin
                                out_status_next = lpbrf_pkg::STATUS_ZERO_LEN;
                            end
                            else if (refuse)
                            begin
                                push_open_next  = (msg_len > lpbrf_pkg::LEN_W'(1));
                                push_drop_next  = 1'b1;
                                push_left_next  = msg_len - lpbrf_pkg::LEN_W'(1);
                                out_status_next = lpbrf_pkg::STATUS_REFUSED;
                            end
                            else
                            begin
                                free_next       = FW'(free_rec_x - len_x);
                                ram_we          = 1'b1;
                                tail_next       = tail_inc;
                                push_left_next  = msg_len - lpbrf_pkg::LEN_W'(1);
                                push_open_next  = (msg_len != lpbrf_pkg::LEN_W'(1));
                                out_status_next = lpbrf_pkg::STATUS_PUSH_OK;
                            end
                        end
                        else if (!push_open_reg)
                        begin
                            out_status_next = lpbrf_pkg::STATUS_REFUSED;
                        end
                        else
                        begin
                            push_left_next = left_dec;
                            if (left_dec == '0)
                            begin
                                push_open_next = 1'b0;
                            end
                            if (push_drop_reg)
                            begin
                                if (left_dec == '0)
                                begin
                                    push_drop_next = 1'b0;
                                end
                                out_status_next = lpbrf_pkg::STATUS_REFUSED;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                tail_next       = tail_inc;
                                out_status_next = lpbrf_pkg::STATUS_PUSH_OK;
                            end
                        end
                    end
                    else if (push_open_reg)
                    begin
                        out_status_next = lpbrf_pkg::STATUS_BUSY;
                    end
                    else if (empty)
                    begin
                        out_status_next = lpbrf_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        // The result is produced once the length byte comes back.
                        out_valid_next = 1'b0;
                        ram_re         = 1'b1;
                        state_next     = ST_POP_LEN;
                    end
                end
            end

            ST_POP_LEN:
            begin
                if (head_len == '0)
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = lpbrf_pkg::STATUS_ZERO_LEN;
                        out_byte_next   = '0;
                        out_len_next    = '0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    // The read data holds the length byte, which is also the first byte out.
                    n_next     = head_len;
                    cnt_next   = head_len;
                    state_next = ST_POP_BYTE;
                end
            end

            ST_POP_BYTE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = lpbrf_pkg::STATUS_POP_BYTE;
                    out_byte_next   = ram_rdata;
                    out_len_next    = n_reg;
                    out_last_next   = (cnt_reg == lpbrf_pkg::LEN_W'(1));
                    ram_we          = 1'b1;
                    ram_waddr       = head_reg;
                    ram_wdata       = '0;
                    head_next       = head_inc;
                    cnt_next        = cnt_reg - lpbrf_pkg::LEN_W'(1);
                    if (cnt_reg == lpbrf_pkg::LEN_W'(1))
                    begin
                        free_next  = (return_sum > XW'(DEPTH)) ? FW'(DEPTH)
                                                               : return_sum[FW-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = head_inc;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            head_reg      <= '0;
            tail_reg      <= '0;
            clr_reg       <= '0;
            free_reg      <= FW'(DEPTH);
            push_open_reg <= 1'b0;
            push_drop_reg <= 1'b0;
            push_left_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            clr_reg       <= clr_next;
            free_reg      <= free_next;
            push_open_reg <= push_open_next;
            push_drop_reg <= push_drop_next;
            push_left_reg <= push_left_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> item_stall)
        else $error("item taken while a pop or the clearing pass is under way");

    assert property (@(posedge clk) disable iff (!rst_n)
        XW'(free_reg) <= XW'(DEPTH))
        else $error("free count above the store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == lpbrf_pkg::STATUS_POP_BYTE)
        |-> (length != '0 && XW'(length) <= XW'(MAX_MSG)))
        else $error("popped byte carries a length outside one to the message limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_BYTE) |-> (cnt_reg != '0 && !push_open_reg))
        else $error("pop byte count ran out or a push is open during a pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_BYTE && slot_free && cnt_reg != lpbrf_pkg::LEN_W'(1))
        |=> (state_reg == ST_POP_BYTE && $stable(free_reg)))
        else $error("pop left early or free count moved before its last byte");
`endif

endmodule
